// ===== sv/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled during reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Plain property check
`define VPV_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition in a cycle implies another in the next cycle
`define VPV_ASSERT_NEXT(label, cond, expect_next) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (expect_next)) else $error("assertion failed");
`else
`define VPV_ASSERT(label, prop)
`define VPV_ASSERT_NEXT(label, cond, expect_next)
`endif

`endif

// ===== sv/vpv_pkg.sv =====
// ============================================================================
// vpv_pkg
// Shared types, constants and helpers of the vertex projection block.
// ============================================================================
package vpv_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int OPND_W      = 34;
    localparam int PROD_W      = 2 * OPND_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int NUM_W       = DATA_W + FRAC_BITS;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 96;
    localparam int CFG_IDX_W   = 3;

    localparam logic signed [DATA_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [ACC_W-1:0]  SAT_HI = ACC_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0]  SAT_LO = ACC_W'(64'shFFFF_FFFF_8000_0000);

    typedef enum logic [1:0] {
        CMD_LOAD_PROJ,
        CMD_LOAD_VIEW,
        CMD_PROJECT,
        CMD_NONE
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEW_LEFT,
        CFG_VIEW_BOTTOM,
        CFG_VIEW_RIGHT,
        CFG_VIEW_TOP,
        CFG_DEPTH_NEAR,
        CFG_DEPTH_FAR
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MM,
        S_MM_WAIT,
        S_CV,
        S_CV_WAIT,
        S_DIV_GO,
        S_DIV_RUN,
        S_VP,
        S_VP_WAIT,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_MM,
        PH_CV,
        PH_VP
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        phase_t     phase;
        logic [3:0] dst;
    } pipe_ctl_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[DATA_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ===== sv/vpv_div.sv =====
// ============================================================================
// vpv_div
// Unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
module vpv_div
    import vpv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DATA_W-1:0] den,
    output logic              done,
    output logic [NUM_W-1:0]  quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DATA_W-1:0] rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DATA_W-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W+1:0] diff;
    logic              ge;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[NUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, den_reg};
        ge     = !diff[DATA_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            // keep the partial remainder, shift in the new quotient bit
            rem_reg <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== sv/vertex_project_to_viewport.sv =====
// ============================================================================
// vertex_project_to_viewport
// Projection times view, point transform, divide by clip w, viewport mapping.
// ============================================================================
//
//  channel | direction | contents
//  --------+-----------+----------------------------------------------------
//  s_      | in        | command in tuser; load element or world point
//  m_      | out       | screen x, y, depth in tdata; not_in_front in tuser
//  cfg_    | in        | viewport and depth range registers, always ready
//
//  Load and unused commands are accepted in idle and do not leave it. A project
//  transaction runs 64 + 16 products through one shared 34x34 multiplier
//  with a three stage read, multiply, accumulate pipe, then three divisions
//  (48 quotient bits each) on a one bit per cycle divider, then 3 viewport
//  products; the divisions are skipped when clip w <= 0.
//  Reset clears the matrices through per-element valid bits and zeroes the
//  viewport and depth registers. The result waits in an output register, so
//  input is taken again while m_tready is low.
//
`include "assert_macros.svh"

module vertex_project_to_viewport
    import vpv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [3:0] element_index, [35:4] element_value, [67:36] world_x,
    // [99:68] world_y, [131:100] world_z, [135:132] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] screen_x, [63:32] screen_y, [95:64] screen_depth
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // [0] not_in_front
    output logic [0:0]             m_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DATA_W-1:0]      cfg_data
);

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] div_idx_reg;

    logic signed [DATA_W-1:0] left_reg, bottom_reg, right_reg, top_reg, near_reg, far_reg;

    logic signed [DATA_W-1:0] p_mem [16];
    logic signed [DATA_W-1:0] v_mem [16];
    logic signed [DATA_W-1:0] m_mem [16];
    logic [15:0]              p_ok_reg, v_ok_reg;

    logic signed [DATA_W-1:0] pt_reg   [3];
    logic signed [DATA_W-1:0] clip_reg [4];
    logic signed [DATA_W-1:0] ndc_reg  [3];
    logic signed [PROD_W-1:0] vp_reg   [3];
    logic                     behind_reg;

    pipe_ctl_t ctl_issue, ctl1_reg, ctl2_reg;
    logic signed [DATA_W-1:0] p_rd_reg, v_rd_reg, m_rd_reg, pt_rd_reg;
    logic                     p_rdok_reg, v_rdok_reg;
    logic signed [DATA_W:0]   vp_a_reg, vp_b_reg;
    logic signed [DATA_W:0]   vp_a_next, vp_b_next;
    logic signed [DATA_W-1:0] pt_rd_next;
    logic signed [OPND_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_base, acc_sum;

    logic              s_accept;
    cmd_t              cmd;
    logic [3:0]        p_addr, v_addr;
    logic              drained;
    logic              behind;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num, div_quo;
    logic [DATA_W-1:0] c_mag;
    logic              c_neg;
    logic signed [ACC_W-1:0] q_signed;

    logic                     out_valid_reg, out_nif_reg, out_load;
    logic signed [DATA_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic signed [DATA_W:0]   half_depth;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cmd       = cmd_t'(s_tuser);
    assign cfg_ready = 1'b1;
    assign drained   = !ctl1_reg.valid && !ctl2_reg.valid;
    assign behind    = clip_reg[3][DATA_W-1] || (clip_reg[3] == '0);
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            bottom_reg <= '0;
            right_reg  <= '0;
            top_reg    <= '0;
            near_reg   <= '0;
            far_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_VIEW_LEFT:   left_reg   <= cfg_data;
                CFG_VIEW_BOTTOM: bottom_reg <= cfg_data;
                CFG_VIEW_RIGHT:  right_reg  <= cfg_data;
                CFG_VIEW_TOP:    top_reg    <= cfg_data;
                CFG_DEPTH_NEAR:  near_reg   <= cfg_data;
                CFG_DEPTH_FAR:   far_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_accept && cmd == CMD_PROJECT)
                    state_next = S_MM;
            S_MM:
                if (cnt_reg == 6'd63)
                    state_next = S_MM_WAIT;
            S_MM_WAIT:
                if (drained)
                    state_next = S_CV;
            S_CV:
                if (cnt_reg == 6'd15)
                    state_next = S_CV_WAIT;
            S_CV_WAIT:
                if (drained)
                    state_next = behind ? S_VP : S_DIV_GO;
            S_DIV_GO:
                state_next = S_DIV_RUN;
            S_DIV_RUN:
                if (div_done)
                    state_next = (div_idx_reg == 2'd2) ? S_VP : S_DIV_GO;
            S_VP:
                if (cnt_reg == 6'd2)
                    state_next = S_VP_WAIT;
            S_VP_WAIT:
                if (drained)
                    state_next = S_OUT;
            S_OUT:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next  = '0;
        ctl_issue = '0;
        div_start = 1'b0;
        unique case (state_reg)
            S_MM:
            begin
                cnt_next        = cnt_reg + 1'b1;
                ctl_issue.valid = 1'b1;
                ctl_issue.phase = PH_MM;
                ctl_issue.first = (cnt_reg[1:0] == 2'd0);
                ctl_issue.last  = (cnt_reg[1:0] == 2'd3);
                ctl_issue.dst   = cnt_reg[5:2];
                if (cnt_reg == 6'd63)
                    cnt_next = '0;
            end
            S_CV:
            begin
                cnt_next        = cnt_reg + 1'b1;
                ctl_issue.valid = 1'b1;
                ctl_issue.phase = PH_CV;
                ctl_issue.first = (cnt_reg[1:0] == 2'd0);
                ctl_issue.last  = (cnt_reg[1:0] == 2'd3);
                ctl_issue.dst   = {2'b00, cnt_reg[3:2]};
                if (cnt_reg == 6'd15)
                    cnt_next = '0;
            end
            S_VP:
            begin
                cnt_next        = cnt_reg + 1'b1;
                ctl_issue.valid = 1'b1;
                ctl_issue.phase = PH_VP;
                ctl_issue.first = 1'b1;
                ctl_issue.last  = 1'b1;
                ctl_issue.dst   = {2'b00, cnt_reg[1:0]};
                if (cnt_reg == 6'd2)
                    cnt_next = '0;
            end
            S_DIV_GO:
                div_start = 1'b1;
            default:
                ;
        endcase
    end

    // ---------------------------------------------------------------- matrices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_ok_reg <= '0;
            v_ok_reg <= '0;
        end
        else if (s_accept)
        begin
            if (cmd == CMD_LOAD_PROJ)
                p_ok_reg[s_tdata[3:0]] <= 1'b1;
            if (cmd == CMD_LOAD_VIEW)
                v_ok_reg[s_tdata[3:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            case (cmd)
                CMD_LOAD_PROJ: p_mem[s_tdata[3:0]] <= s_tdata[35:4];
                CMD_LOAD_VIEW: v_mem[s_tdata[3:0]] <= s_tdata[35:4];
                CMD_PROJECT:
                begin
                    pt_reg[0] <= s_tdata[67:36];
                    pt_reg[1] <= s_tdata[99:68];
                    pt_reg[2] <= s_tdata[131:100];
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- stage 1: read
    assign p_addr = {cnt_reg[5:4], cnt_reg[1:0]};
    assign v_addr = {cnt_reg[1:0], cnt_reg[3:2]};

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    pt_rd_next = pt_reg[0];
            2'd1:    pt_rd_next = pt_reg[1];
            2'd2:    pt_rd_next = pt_reg[2];
            default: pt_rd_next = ONE;
        endcase
        case (cnt_reg[1:0])
            2'd0:
            begin
                vp_a_next = (DATA_W+1)'(right_reg) - (DATA_W+1)'(left_reg);
                vp_b_next = (DATA_W+1)'(ONE) + (DATA_W+1)'(ndc_reg[0]);
            end
            2'd1:
            begin
                vp_a_next = (DATA_W+1)'(top_reg) - (DATA_W+1)'(bottom_reg);
                vp_b_next = (DATA_W+1)'(ONE) + (DATA_W+1)'(ndc_reg[1]);
            end
            default:
            begin
                vp_a_next = (DATA_W+1)'(far_reg) - (DATA_W+1)'(near_reg);
                vp_b_next = (DATA_W+1)'(ndc_reg[2]);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_issue;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_rd_reg   <= p_mem[p_addr];
        v_rd_reg   <= v_mem[v_addr];
        p_rdok_reg <= p_ok_reg[p_addr];
        v_rdok_reg <= v_ok_reg[v_addr];
        m_rd_reg   <= m_mem[cnt_reg[3:0]];
        pt_rd_reg  <= pt_rd_next;
        vp_a_reg   <= vp_a_next;
        vp_b_reg   <= vp_b_next;
    end

    // ---------------------------------------------------------------- stage 2: multiply
    always_comb
    begin
        case (ctl1_reg.phase)
            PH_MM:
            begin
                mul_a = p_rdok_reg ? OPND_W'(p_rd_reg) : '0;
                mul_b = v_rdok_reg ? OPND_W'(v_rd_reg) : '0;
            end
            PH_CV:
            begin
                mul_a = OPND_W'(m_rd_reg);
                mul_b = OPND_W'(pt_rd_reg);
            end
            default:
            begin
                mul_a = OPND_W'(vp_a_reg);
                mul_b = OPND_W'(vp_b_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // ---------------------------------------------------------------- stage 3: accumulate
    always_comb
    begin
        acc_base = ctl2_reg.first ? ACC_W'(0) : acc_reg;
        acc_sum  = acc_base + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl2_reg.valid)
        begin
            acc_reg <= acc_sum;
            if (ctl2_reg.last)
            begin
                case (ctl2_reg.phase)
                    PH_MM: m_mem[ctl2_reg.dst] <= sat32(acc_sum >>> FRAC_BITS);
                    PH_CV: clip_reg[ctl2_reg.dst[1:0]] <= sat32(acc_sum >>> FRAC_BITS);
                    default:
                    begin
                        case (ctl2_reg.dst[1:0])
                            2'd0:    vp_reg[0] <= prod_reg >>> (FRAC_BITS + 1);
                            2'd1:    vp_reg[1] <= prod_reg >>> (FRAC_BITS + 1);
                            2'd2:    vp_reg[2] <= prod_reg >>> (FRAC_BITS + 1);
                            default: ;
                        endcase
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- divide
    always_comb
    begin
        c_neg    = clip_reg[div_idx_reg][DATA_W-1];
        c_mag    = c_neg ? (~clip_reg[div_idx_reg] + 1'b1) : clip_reg[div_idx_reg];
        div_num  = {c_mag, {FRAC_BITS{1'b0}}};
        q_signed = c_neg ? -$signed(ACC_W'(div_quo)) : $signed(ACC_W'(div_quo));
    end

    vpv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (clip_reg[3]),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_idx_reg <= '0;
        else if (state_reg == S_CV_WAIT)
            div_idx_reg <= '0;
        else if (state_reg == S_DIV_RUN && div_done)
            div_idx_reg <= div_idx_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CV_WAIT && drained)
        begin
            // zero until the divider writes them; stays zero behind the eye
            ndc_reg[0] <= '0;
            ndc_reg[1] <= '0;
            ndc_reg[2] <= '0;
            behind_reg <= behind;
        end
        else if (state_reg == S_DIV_RUN && div_done)
        begin
            case (div_idx_reg)
                2'd0:    ndc_reg[0] <= sat32(q_signed);
                2'd1:    ndc_reg[1] <= sat32(q_signed);
                default: ndc_reg[2] <= sat32(q_signed);
            endcase
        end
    end

    // ---------------------------------------------------------------- output
    assign half_depth = ((DATA_W+1)'(near_reg) + (DATA_W+1)'(far_reg)) >>> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg   <= sat32(ACC_W'(left_reg) + ACC_W'(vp_reg[0]));
            out_y_reg   <= sat32(ACC_W'(bottom_reg) + ACC_W'(vp_reg[1]));
            out_z_reg   <= sat32(ACC_W'(vp_reg[2]) + ACC_W'(half_depth));
            out_nif_reg <= behind_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_z_reg, out_y_reg, out_x_reg};
    assign m_tuser[0] = out_nif_reg;

    // ---------------------------------------------------------------- checks
    `VPV_ASSERT(a_accept_drained, (s_tvalid && s_tready) |-> (!ctl1_reg.valid && !ctl2_reg.valid))
    `VPV_ASSERT_NEXT(a_project_busy, s_tvalid && s_tready && s_tuser == CMD_PROJECT, !s_tready)
    `VPV_ASSERT_NEXT(a_out_loaded, out_load, m_tvalid)
    `VPV_ASSERT(a_div_in_front, div_start |-> !behind)

endmodule
